// File: rtl/core/thick_segment_tessellator_unit_assert.svh
// Assertion macros for the thick segment tessellator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef THICK_SEGMENT_TESSELLATOR_UNIT_ASSERT_SVH
`define THICK_SEGMENT_TESSELLATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TSTU_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  (prop)) else $error("tessellator check failed");
`define TSTU_ASSERT_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clk_i) \
  disable iff (!rst_ni) (ante) |=> (cons)) else $error("tessellator check failed");
`else
`define TSTU_ASSERT(lbl, prop)
`define TSTU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/tstu_pkg.sv
// Package for the thick segment tessellator: types, stage map, vertex tables.
// No dependencies.
package tstu_pkg;

  localparam int TEX_SHIFT   = 14;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 15;
  localparam int ST_SQRT0    = 3;
  localparam int ST_DIVSETUP = ST_SQRT0 + SQRT_STEPS;
  localparam int ST_DIV0     = ST_DIVSETUP + 1;
  localparam int ST_PROD     = ST_DIV0 + DIV_STEPS;
  localparam int NUM_STAGES  = ST_PROD + 1;

  localparam logic [2:0] REG_CULL_EN = 3'd0;
  localparam logic [2:0] REG_MIN_X   = 3'd1;
  localparam logic [2:0] REG_MIN_Y   = 3'd2;
  localparam logic [2:0] REG_MAX_X   = 3'd3;
  localparam logic [2:0] REG_MAX_Y   = 3'd4;

  localparam logic [4:0] K_BODY_FIRST = 5'd6;
  localparam logic [4:0] K_BODY_LAST  = 5'd11;
  localparam logic [4:0] K_CAP_LAST   = 5'd17;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [30:0]        r;
    logic [31:0]        color;
    logic               ec;
    logic               sc;
    logic               culled;
    logic               dxneg;
    logic               dyneg;
  } ctx_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [30:0] mx;
    logic [30:0] my;
    logic [61:0] sqx;
    logic [61:0] sqy;
    logic [62:0] acc;
    logic [63:0] res;
    logic [31:0] len;
    logic [46:0] remx;
    logic [46:0] remy;
    logic [14:0] qx;
    logic [14:0] qy;
    logic [31:0] pmx;
    logic [31:0] pmy;
  } pipe_t;

  localparam logic [2:0] VERT_SEL [18] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd1, 3'd2, 3'd3, 3'd4, 3'd2,
    3'd3, 3'd4, 3'd5, 3'd6, 3'd4, 3'd5, 3'd6, 3'd7, 3'd5};
  // Texture kinds: n, -n, -(n+t), n-t, t-n, n+t.
  localparam logic [2:0] TEX_SEL [18] = '{
    3'd2, 3'd3, 3'd1, 3'd0, 3'd3, 3'd1, 3'd0, 3'd1, 3'd1,
    3'd0, 3'd1, 3'd0, 3'd4, 3'd1, 3'd0, 3'd4, 3'd5, 3'd0};

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] o;
    if (v > 35'sd2147483647) o = 32'h7FFF_FFFF;
    else if (v < -35'sd2147483648) o = 32'h8000_0000;
    else o = v[31:0];
    return o;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [17:0] v);
    logic [15:0] o;
    if (v > 18'sd32767) o = 16'h7FFF;
    else if (v < -18'sd32768) o = 16'h8000;
    else o = v[15:0];
    return o;
  endfunction

endpackage

// File: rtl/core/thick_segment_tessellator_unit.sv
// Thick segment tessellator top level: deep arithmetic pipeline plus vertex sequencer.
// Depends on tstu_pkg and thick_segment_tessellator_unit_assert.svh.
//
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  input   | in_valid_i / in_ready_o, fields | in
//  result  | out_valid_o / out_ready_i       | out
//  config  | cfg_valid_i / cfg_ready_o       | in
//
// A segment crosses 52 register stages: operand setup, squares, sum, a 32-step
// square root (one step per stage), divide setup, a 15-step restoring divide per
// axis, and the width multiply. The vertex sequencer then emits 6, 12 or 18
// vertices per segment (one transaction when culled); that sequencer sets the
// sustained rate. The whole pipeline advances together while the sequencer is
// free or finishing its last transaction, so a stall holds every stage. Reset
// clears valid bits, the sequencer index and the config registers, not data.
`include "thick_segment_tessellator_unit_assert.svh"
module thick_segment_tessellator_unit import tstu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  input  logic [30:0]        half_width_i,
  input  logic [31:0]        color_rgba_i,
  input  logic               end_cap_on_i,
  input  logic               start_cap_on_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] vert_x_o,
  output logic signed [31:0] vert_y_o,
  output logic signed [15:0] tex_u_o,
  output logic signed [15:0] tex_v_o,
  output logic [31:0]        vert_color_o,
  output logic               culled_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  // Configuration registers.
  logic               cull_en_q;
  logic signed [31:0] min_x_q, min_y_q, max_x_q, max_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cull_en_q <= 1'b0;
      min_x_q   <= '0;
      min_y_q   <= '0;
      max_x_q   <= '0;
      max_y_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CULL_EN: cull_en_q <= cfg_data_i[0];
        REG_MIN_X:   min_x_q   <= cfg_data_i;
        REG_MIN_Y:   min_y_q   <= cfg_data_i;
        REG_MAX_X:   max_x_q   <= cfg_data_i;
        REG_MAX_Y:   max_y_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline. Every stage moves when adv is high.
  logic  adv;
  pipe_t pipe_q [NUM_STAGES];
  pipe_t pipe_d [NUM_STAGES];
  logic  vld_q  [NUM_STAGES];

  assign in_ready_o = adv;

  // Stage 0: cull test, direction and magnitudes.
  always_comb begin
    logic signed [32:0] dx, dy;
    logic [31:0] magx, magy;
    logic big;
    pipe_d[0] = '0;
    pipe_d[0].ctx.ax = start_x_i;
    pipe_d[0].ctx.ay = start_y_i;
    pipe_d[0].ctx.bx = end_x_i;
    pipe_d[0].ctx.by = end_y_i;
    pipe_d[0].ctx.r = half_width_i;
    pipe_d[0].ctx.color = color_rgba_i;
    pipe_d[0].ctx.ec = end_cap_on_i;
    pipe_d[0].ctx.sc = start_cap_on_i;
    pipe_d[0].ctx.culled = cull_en_q &&
        ((start_x_i < min_x_q && end_x_i < min_x_q) ||
         (start_x_i > max_x_q && end_x_i > max_x_q) ||
         (start_y_i < min_y_q && end_y_i < min_y_q) ||
         (start_y_i > max_y_q && end_y_i > max_y_q));
    dx = 33'(end_x_i) - 33'(start_x_i);
    dy = 33'(end_y_i) - 33'(start_y_i);
    magx = dx[32] ? 32'(-dx) : dx[31:0];
    magy = dy[32] ? 32'(-dy) : dy[31:0];
    big = magx[31] | magy[31];
    pipe_d[0].ctx.dxneg = dx[32];
    pipe_d[0].ctx.dyneg = dy[32];
    pipe_d[0].mx = big ? magx[31:1] : magx[30:0];
    pipe_d[0].my = big ? magy[31:1] : magy[30:0];
  end

  // Stage 1: squares.
  always_comb begin
    pipe_d[1] = pipe_q[0];
    pipe_d[1].sqx = 62'(pipe_q[0].mx) * 62'(pipe_q[0].mx);
    pipe_d[1].sqy = 62'(pipe_q[0].my) * 62'(pipe_q[0].my);
  end

  // Stage 2: sum of squares, sqrt seed.
  always_comb begin
    pipe_d[2] = pipe_q[1];
    pipe_d[2].acc = 63'(pipe_q[1].sqx) + 63'(pipe_q[1].sqy);
    pipe_d[2].res = '0;
  end

  // Square root: one bit pair per stage.
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam int BP = 62 - 2 * j;
    always_comb begin
      logic [63:0] trial;
      pipe_d[ST_SQRT0 + j] = pipe_q[ST_SQRT0 + j - 1];
      trial = pipe_q[ST_SQRT0 + j - 1].res + (64'd1 << BP);
      if (64'(pipe_q[ST_SQRT0 + j - 1].acc) >= trial) begin
        pipe_d[ST_SQRT0 + j].acc = pipe_q[ST_SQRT0 + j - 1].acc - trial[62:0];
        pipe_d[ST_SQRT0 + j].res = (pipe_q[ST_SQRT0 + j - 1].res >> 1) + (64'd1 << BP);
      end else begin
        pipe_d[ST_SQRT0 + j].res = pipe_q[ST_SQRT0 + j - 1].res >> 1;
      end
    end
  end

  // Divide setup: numerators with half the length added for rounding.
  always_comb begin
    logic [31:0] l;
    pipe_d[ST_DIVSETUP] = pipe_q[ST_DIVSETUP - 1];
    l = pipe_q[ST_DIVSETUP - 1].res[31:0];
    pipe_d[ST_DIVSETUP].len = l;
    pipe_d[ST_DIVSETUP].remx = (47'(pipe_q[ST_DIVSETUP - 1].mx) << TEX_SHIFT) + 47'(l[31:1]);
    pipe_d[ST_DIVSETUP].remy = (47'(pipe_q[ST_DIVSETUP - 1].my) << TEX_SHIFT) + 47'(l[31:1]);
    pipe_d[ST_DIVSETUP].qx = '0;
    pipe_d[ST_DIVSETUP].qy = '0;
  end

  // Restoring divide, one quotient bit per stage for both axes.
  for (genvar t = 0; t < DIV_STEPS; t++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - t;
    always_comb begin
      logic [46:0] dv;
      pipe_d[ST_DIV0 + t] = pipe_q[ST_DIV0 + t - 1];
      dv = 47'(pipe_q[ST_DIV0 + t - 1].len) << SH;
      if (pipe_q[ST_DIV0 + t - 1].remx >= dv) begin
        pipe_d[ST_DIV0 + t].remx = pipe_q[ST_DIV0 + t - 1].remx - dv;
        pipe_d[ST_DIV0 + t].qx[SH] = 1'b1;
      end
      if (pipe_q[ST_DIV0 + t - 1].remy >= dv) begin
        pipe_d[ST_DIV0 + t].remy = pipe_q[ST_DIV0 + t - 1].remy - dv;
        pipe_d[ST_DIV0 + t].qy[SH] = 1'b1;
      end
    end
  end

  // Width products, rounded half up on the magnitude.
  always_comb begin
    logic [14:0] qx, qy;
    logic [46:0] px, py;
    pipe_d[ST_PROD] = pipe_q[ST_PROD - 1];
    qx = (pipe_q[ST_PROD - 1].len == '0) ? '0 : pipe_q[ST_PROD - 1].qx;
    qy = (pipe_q[ST_PROD - 1].len == '0) ? '0 : pipe_q[ST_PROD - 1].qy;
    px = 47'(46'(qx) * 46'(pipe_q[ST_PROD - 1].ctx.r)) + (47'd1 << (TEX_SHIFT - 1));
    py = 47'(46'(qy) * 46'(pipe_q[ST_PROD - 1].ctx.r)) + (47'd1 << (TEX_SHIFT - 1));
    pipe_d[ST_PROD].qx = qx;
    pipe_d[ST_PROD].qy = qy;
    pipe_d[ST_PROD].pmx = px[45:14];
    pipe_d[ST_PROD].pmy = py[45:14];
  end

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (adv) begin
        vld_q[i] <= (i == 0) ? in_valid_i : vld_q[(i == 0) ? 0 : i - 1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pipe_q[i] <= pipe_d[i];
      end
    end
  end

  // Corner and texture build from the last stage, loaded into the sequencer.
  pipe_t              fin;
  logic signed [34:0] cx [8];
  logic signed [34:0] cy [8];
  logic signed [17:0] cu [6];
  logic signed [17:0] cv [6];

  assign fin = pipe_q[NUM_STAGES - 1];

  always_comb begin
    logic signed [17:0] nx, ny, tx, ty;
    logic signed [34:0] nwx, nwy, twx, twy, ax, ay, bx, by;
    nx  = fin.ctx.dyneg ? 18'(fin.qy) : -18'(fin.qy);
    ny  = fin.ctx.dxneg ? -18'(fin.qx) : 18'(fin.qx);
    tx  = -ny;
    ty  = nx;
    nwx = fin.ctx.dyneg ? 35'(fin.pmy) : -35'(fin.pmy);
    nwy = fin.ctx.dxneg ? -35'(fin.pmx) : 35'(fin.pmx);
    twx = -nwy;
    twy = nwx;
    ax  = 35'(fin.ctx.ax);
    ay  = 35'(fin.ctx.ay);
    bx  = 35'(fin.ctx.bx);
    by  = 35'(fin.ctx.by);
    cx[0] = bx - nwx - twx;  cy[0] = by - nwy - twy;
    cx[1] = bx + nwx - twx;  cy[1] = by + nwy - twy;
    cx[2] = bx - nwx;        cy[2] = by - nwy;
    cx[3] = bx + nwx;        cy[3] = by + nwy;
    cx[4] = ax - nwx;        cy[4] = ay - nwy;
    cx[5] = ax + nwx;        cy[5] = ay + nwy;
    cx[6] = ax - nwx + twx;  cy[6] = ay - nwy + twy;
    cx[7] = ax + nwx + twx;  cy[7] = ay + nwy + twy;
    cu[0] = nx;          cv[0] = ny;
    cu[1] = -nx;         cv[1] = -ny;
    cu[2] = -(nx + tx);  cv[2] = -(ny + ty);
    cu[3] = nx - tx;     cv[3] = ny - ty;
    cu[4] = tx - nx;     cv[4] = ty - ny;
    cu[5] = nx + tx;     cv[5] = ny + ty;
  end

  // Vertex sequencer: holds one segment's saturated corners and walks the list.
  logic        seq_vld_q, seq_vld_d;
  logic [4:0]  k_q, k_d, lastk_q;
  logic        cul_q;
  logic [31:0] col_q;
  logic [31:0] px_q [8];
  logic [31:0] py_q [8];
  logic [15:0] tu_q [6];
  logic [15:0] tv_q [6];
  logic        ld, fire, is_last;
  logic [2:0]  vs, ts;

  assign ld      = adv && vld_q[NUM_STAGES - 1];
  assign fire    = out_valid_o && out_ready_i;
  assign is_last = cul_q || (k_q == lastk_q);
  assign adv     = !seq_vld_q || (out_ready_i && is_last);

  always_comb begin
    seq_vld_d = seq_vld_q;
    k_d       = k_q;
    if (ld) begin
      seq_vld_d = 1'b1;
      k_d       = fin.ctx.ec ? '0 : K_BODY_FIRST;
    end else if (fire) begin
      if (is_last) seq_vld_d = 1'b0;
      else k_d = k_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_vld_q <= 1'b0;
      k_q       <= '0;
    end else begin
      seq_vld_q <= seq_vld_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      lastk_q <= fin.ctx.sc ? K_CAP_LAST : K_BODY_LAST;
      cul_q   <= fin.ctx.culled;
      col_q   <= fin.ctx.color;
      for (int v = 0; v < 8; v++) begin
        px_q[v] <= sat32(cx[v]);
        py_q[v] <= sat32(cy[v]);
      end
      for (int v = 0; v < 6; v++) begin
        tu_q[v] <= sat16(cu[v]);
        tv_q[v] <= sat16(cv[v]);
      end
    end
  end

  assign vs           = VERT_SEL[k_q];
  assign ts           = TEX_SEL[k_q];
  assign out_valid_o  = seq_vld_q;
  assign vert_x_o     = cul_q ? '0 : px_q[vs];
  assign vert_y_o     = cul_q ? '0 : py_q[vs];
  assign tex_u_o      = cul_q ? '0 : tu_q[ts];
  assign tex_v_o      = cul_q ? '0 : tv_q[ts];
  assign vert_color_o = cul_q ? '0 : col_q;
  assign culled_o     = cul_q;
  assign last_o       = is_last;

  // A culled segment is one transaction only.
  `TSTU_ASSERT(a_culled_last, !(out_valid_o && culled_o) || last_o)
  // The vertex index never passes the final one of its segment.
  `TSTU_ASSERT(a_k_range, !seq_vld_q || cul_q || k_q <= lastk_q)
  // A segment ends on a body or start-cap close.
  `TSTU_ASSERT(a_last_pos, !(out_valid_o && last_o && !culled_o) ||
      k_q == K_BODY_LAST || k_q == K_CAP_LAST)
  // The final transaction with nothing waiting empties the sequencer.
  `TSTU_ASSERT_NEXT(a_drain, fire && is_last && !vld_q[NUM_STAGES - 1], !seq_vld_q)

endmodule
